[hdl/kruskal_maze_wall_remover_defines.svh]
// assertion macros for the maze wall remover
`ifndef KRUSKAL_MAZE_WALL_REMOVER_DEFINES_SVH
`define KRUSKAL_MAZE_WALL_REMOVER_DEFINES_SVH

`define KMW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define KMW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/kmw_pkg.sv]
// ----------------------------------------------------------------------------
// kmw_pkg
// types and constants shared by the maze wall remover
// ----------------------------------------------------------------------------
package kmw_pkg;

  localparam int unsigned MaxSideDef  = 32;
  localparam int unsigned MaxCellsDef = 1024;
  localparam int unsigned MaxWallsDef = 2048;

  localparam logic [1:0] StatDraw    = 2'd0;
  localparam logic [1:0] StatBegin   = 2'd1;
  localparam logic [1:0] StatIgnored = 2'd2;

  localparam logic ReqBegin = 1'b0;
  localparam logic ReqDraw  = 1'b1;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_MOD,
    ST_RDW,
    ST_WALL,
    ST_FA_RD,
    ST_FA_CHK,
    ST_FB_RD,
    ST_FB_CHK,
    ST_UNION,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_e;

endpackage

[hdl/kruskal_maze_wall_remover.sv]
// ----------------------------------------------------------------------------
// kruskal_maze_wall_remover
// randomized kruskal maze generator: wall list and union-find sets in memory
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  request  | start_i, req_type_i, random_value_i     | start_i & !busy_o
//  result   | cell_index_o .. status_o                | done_o, one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i         | cfg_we_i
//
// a begin writes the parent and wall lists side by side in its init sweep;
// a begin that does not fit goes straight to the result
// a draw waits for the divider, walks each root one parent hop at a time and
// moves each later wall down in the list; an ignored draw skips the divider
// the result strobe follows in the cycle after the last busy cycle
// reset clears control state only; the memories are written by each begin
// results cannot be stalled
module kruskal_maze_wall_remover import kmw_pkg::*; #(
  parameter int unsigned MAX_SIDE  = MaxSideDef,
  parameter int unsigned MAX_CELLS = MaxCellsDef,
  parameter int unsigned MAX_WALLS = MaxWallsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [30:0] random_value_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  output logic        done_o,
  output logic [9:0]  cell_index_o,
  output logic [9:0]  neighbor_index_o,
  output logic        wall_side_o,
  output logic        wall_removed_o,
  output logic        maze_complete_o,
  output logic [1:0]  status_o
);

  localparam int unsigned CW = $clog2(MAX_CELLS);
  localparam int unsigned WW = $clog2(MAX_WALLS);
  localparam int unsigned NW = WW + 1;
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW = 2 * SW + 2;

  logic [CW-1:0] parent_mem [MAX_CELLS];
  logic [CW:0]   wall_mem   [MAX_WALLS];

  state_e state_q, state_d;

  logic [5:0]    rows_q, cols_q;
  logic [SW-1:0] act_cols_q;
  logic [NW-1:0] walls_q;
  logic [CW:0]   sets_q;
  logic          active_q;

  logic [NW-1:0] pos_q;
  logic [CW:0]   cell_q, nb_q, cur_q, ra_q;
  logic          side_q, removed_q;
  logic [CW:0]   wrd_q;
  logic [1:0]    stat_q;

  // begin sweep
  logic [SW-1:0] r_q, c_q, br_q, bc_q;
  logic          half_q;
  logic [CW:0]   ccnt_q, bcells_q;
  logic [NW-1:0] wcnt_q;

  // memory ports
  logic [CW-1:0] p_rdata_q;
  logic [CW:0]   w_rdata_q;
  logic [CW-1:0] p_raddr, p_waddr, p_wdata;
  logic          p_we;
  logic [WW-1:0] w_raddr, w_waddr;
  logic [CW:0]   w_wdata;
  logic          w_we;

  logic          div_start, div_done;
  logic [NW-1:0] div_rem;

  kmw_divider #(.DW(NW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(random_value_i),
    .divisor_i (walls_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  // begin geometry
  logic [SW-1:0] rows_c, cols_c;
  logic [PW-1:0] cells_c, walls_c;
  logic          fits_c;

  function automatic logic [SW-1:0] clamp(input logic [5:0] v);
    logic [SW-1:0] res;
    if (v < 6'd2) res = SW'(2);
    else if ({{(PW){1'b0}}, v} > (PW + 6)'(MAX_SIDE)) res = SW'(MAX_SIDE);
    else res = SW'(v);
    return res;
  endfunction

  assign rows_c  = clamp(rows_q);
  assign cols_c  = clamp(cols_q);
  assign cells_c = PW'(rows_c) * PW'(cols_c);
  assign walls_c = (cells_c << 1) - PW'(rows_c) - PW'(cols_c);
  assign fits_c  = (cells_c <= PW'(MAX_CELLS)) && (walls_c <= PW'(MAX_WALLS));

  logic accept, ign_draw, root_a, root_b;
  assign accept   = start_i && (state_q == ST_IDLE);
  assign ign_draw = !active_q || (sets_q <= (CW + 1)'(1)) || (walls_q == '0);
  assign root_a   = ({1'b0, p_rdata_q} == cur_q);
  assign root_b   = root_a;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        if (req_type_i == ReqBegin) state_d = fits_c ? ST_INIT : ST_DONE;
        else state_d = ST_MOD;
      end
      ST_INIT: if (ccnt_q == bcells_q && r_q == br_q) state_d = ST_DONE;
      ST_MOD: begin
        if (ign_draw) state_d = ST_DONE;
        else if (div_done) state_d = ST_RDW;
      end
      ST_RDW:    state_d = ST_WALL;
      ST_WALL:   state_d = ST_FA_RD;
      ST_FA_RD:  state_d = ST_FA_CHK;
      ST_FA_CHK: state_d = root_a ? ST_FB_RD : ST_FA_RD;
      ST_FB_RD:  state_d = ST_FB_CHK;
      ST_FB_CHK: state_d = root_b ? ST_UNION : ST_FB_RD;
      ST_UNION:  state_d = ST_SH_RD;
      ST_SH_RD:  state_d = (pos_q + NW'(1) >= walls_q) ? ST_DONE : ST_SH_WR;
      ST_SH_WR:  state_d = ST_SH_RD;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o    = (state_q != ST_IDLE);
    div_start = (state_q == ST_IDLE) && accept && (req_type_i == ReqDraw);
    p_raddr   = cur_q[CW-1:0];
    p_we      = 1'b0;
    p_waddr   = ccnt_q[CW-1:0];
    p_wdata   = ccnt_q[CW-1:0];
    w_raddr   = pos_q[WW-1:0];
    w_we      = 1'b0;
    w_waddr   = wcnt_q[WW-1:0];
    w_wdata   = wrd_q;
    case (state_q)
      ST_INIT: begin
        p_we = (ccnt_q != bcells_q);
        w_we = (r_q != br_q) &&
               ((!half_q && (r_q + SW'(1) < br_q)) || (half_q && (c_q != '0)));
        w_wdata = {(CW)'(PW'(r_q) * PW'(act_cols_q) + PW'(c_q)), half_q};
      end
      ST_FA_RD, ST_FB_RD: p_raddr = cur_q[CW-1:0];
      ST_UNION: begin
        p_we    = (ra_q != cur_q);
        p_waddr = ra_q[CW-1:0];
        p_wdata = cur_q[CW-1:0];
      end
      ST_SH_RD: w_raddr = WW'(pos_q + NW'(1));
      ST_SH_WR: begin
        w_we    = 1'b1;
        w_waddr = pos_q[WW-1:0];
        w_wdata = w_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    p_rdata_q <= parent_mem[p_raddr];
    if (w_we) wall_mem[w_waddr] <= w_wdata;
    w_rdata_q <= wall_mem[w_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rows_q     <= 6'd2;
      cols_q     <= 6'd2;
      act_cols_q <= SW'(2);
      walls_q    <= '0;
      sets_q     <= '0;
      active_q   <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgRows) rows_q <= cfg_data_i;
        else cols_q <= cfg_data_i;
        active_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (accept && req_type_i == ReqBegin) begin
          if (fits_c) begin
            act_cols_q <= cols_c;
            walls_q    <= NW'(walls_c);
            sets_q     <= (CW + 1)'(cells_c);
            active_q   <= 1'b1;
          end else begin
            active_q <= 1'b0;
          end
        end
        ST_UNION: if (ra_q != cur_q) sets_q <= sets_q - (CW + 1)'(1);
        ST_SH_RD: if (pos_q + NW'(1) >= walls_q) walls_q <= walls_q - NW'(1);
        ST_DONE: done_o <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        removed_q <= 1'b0;
        cell_q    <= '0;
        nb_q      <= '0;
        side_q    <= 1'b0;
        stat_q    <= (req_type_i == ReqBegin) ? (fits_c ? StatBegin : StatIgnored)
                                              : StatDraw;
        r_q <= '0; c_q <= '0; half_q <= 1'b0;
        ccnt_q <= '0; wcnt_q <= '0;
        br_q <= rows_c; bc_q <= cols_c;
        bcells_q <= (CW + 1)'(cells_c);
      end
      ST_INIT: begin
        if (ccnt_q != bcells_q) ccnt_q <= ccnt_q + (CW + 1)'(1);
        if (r_q != br_q) begin
          if (w_we) wcnt_q <= wcnt_q + NW'(1);
          if (!half_q) half_q <= 1'b1;
          else begin
            half_q <= 1'b0;
            if (c_q == bc_q - SW'(1)) begin
              c_q <= '0;
              r_q <= r_q + SW'(1);
            end else c_q <= c_q + SW'(1);
          end
        end
      end
      ST_MOD: begin
        if (ign_draw) stat_q <= StatIgnored;
        pos_q <= div_rem;
      end
      ST_WALL: begin
        cell_q <= {1'b0, w_rdata_q[CW:1]};
        side_q <= w_rdata_q[0];
        nb_q   <= w_rdata_q[0] ? {1'b0, w_rdata_q[CW:1]} - (CW + 1)'(1)
                               : {1'b0, w_rdata_q[CW:1]} + (CW + 1)'(act_cols_q);
        cur_q  <= {1'b0, w_rdata_q[CW:1]};
      end
      ST_FA_CHK: begin
        if (root_a) begin
          ra_q  <= cur_q;
          cur_q <= nb_q;
        end else cur_q <= {1'b0, p_rdata_q};
      end
      ST_FB_CHK: if (!root_b) cur_q <= {1'b0, p_rdata_q};
      ST_UNION: removed_q <= (ra_q != cur_q);
      ST_SH_WR: pos_q <= pos_q + NW'(1);
      default: ;
    endcase
    if (state_q == ST_RDW) wrd_q <= '0;
  end

  assign cell_index_o     = 10'(cell_q);
  assign neighbor_index_o = 10'(nb_q);
  assign wall_side_o      = side_q;
  assign wall_removed_o   = removed_q;
  assign status_o         = stat_q;
  assign maze_complete_o  = active_q && (sets_q <= (CW + 1)'(1));

endmodule

[hdl/kmw_divider.sv]
// ----------------------------------------------------------------------------
// kmw_divider
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kmw_divider import kmw_pkg::*; #(
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [30:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);

  logic [30:0]   num_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] div_q;
  logic [4:0]    cnt_q;
  logic          run_q;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_q[DW-1:0], num_q[30]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd30;
      end else if (run_q) begin
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[29:0], 1'b0};
      rem_q <= diff[DW] ? shifted : diff;
    end
  end

  assign rem_o = rem_q[DW-1:0];

endmodule

[hdl/kmw_checker.sv]
// ----------------------------------------------------------------------------
// kmw_checker
// port level checks for the maze wall remover
// ----------------------------------------------------------------------------
`include "kruskal_maze_wall_remover_defines.svh"

module kmw_checker import kmw_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       wall_removed_o,
  input logic [1:0] status_o
);

  `KMW_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `KMW_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `KMW_ASSERT_IMPL(a_status_ok, clk_i, rst_ni, done_o,
    status_o == StatDraw || status_o == StatBegin || status_o == StatIgnored)
  `KMW_ASSERT_IMPL(a_removed_draw, clk_i, rst_ni, done_o && wall_removed_o,
    status_o == StatDraw)
  `KMW_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

bind kruskal_maze_wall_remover kmw_checker u_kmw_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .wall_removed_o, .status_o
);
